/* rtl/adfp_pkg.sv */
// Shared types and constants for the advertising data filter and parser.
// No dependencies; used by adfp_walk and advertising_data_filter_parser.
`default_nettype none

package adfp_pkg;

  // AD structure type codes
  localparam logic [7:0] AD_FLAGS      = 8'h01;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;

  // flags bits checked by the discovery filter
  localparam logic [7:0] FLAG_LIMITED = 8'h01;
  localparam logic [7:0] FLAG_GENERAL = 8'h02;

  localparam logic [5:0] POS_MAX = 6'd63;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [1:0] {
    DISC_ALL     = 2'd0,
    DISC_LIMITED = 2'd1,
    DISC_GENERAL = 2'd2
  } disc_e;

  typedef enum logic [1:0] {
    HDR_LEN  = 2'd0,
    HDR_TYPE = 2'd1,
    HDR_DATA = 2'd2
  } hdr_e;

  typedef enum logic [1:0] {
    NAME_NONE    = 2'd0,
    NAME_STREAM  = 2'd1,
    NAME_FOUND   = 2'd2,
    NAME_UNKNOWN = 2'd3
  } name_e;

  typedef struct packed {
    logic [7:0] ad_byte;
    logic [4:0] report_length;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       name_char_valid;
    logic       report_done;
    logic       accept;
    logic       flags_found;
    logic [7:0] flags_value;
    logic       name_status;
    logic [4:0] name_length;
  } out_t;

  // results produced by one byte: name byte first, then summary
  typedef struct packed {
    logic name_vld;
    logic sum_vld;
    out_t name_res;
    out_t sum_res;
  } walk_res_t;

endpackage

`default_nettype wire

/* rtl/adfp_walk.sv */
// LTV walker: per-report state and the combinational step for one byte.
// Depends on adfp_pkg.
`default_nettype none

module adfp_walk #(
  parameter int NAME_MAX = 29
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    fire_i,
  input  adfp_pkg::in_t          item_i,
  input  adfp_pkg::disc_e        mode_i,
  output adfp_pkg::walk_res_t    res_o
);

  logic [5:0]      pos_q, pos_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      kind_q, kind_d;
  adfp_pkg::hdr_e  hdr_q, hdr_d;
  logic            stopped_q, stopped_d;
  logic            seen_q, seen_d;
  logic [7:0]      store_q, store_d;
  adfp_pkg::name_e name_q, name_d;
  logic [4:0]      count_q, count_d;

  logic            active;
  logic            name_hit;
  logic [8:0]      end_pos;
  logic [7:0]      rem_dec;
  logic            pass;

  function automatic logic is_name(input logic [7:0] k);
    return (k == adfp_pkg::AD_NAME_SHORT) || (k == adfp_pkg::AD_NAME_FULL);
  endfunction

  assign active  = !stopped_q && (pos_q < {1'b0, item_i.report_length});
  assign end_pos = 9'(pos_q) + 9'd1 + 9'(item_i.ad_byte);
  assign rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;

  // next state for one byte
  always_comb begin
    pos_d     = (pos_q < adfp_pkg::POS_MAX) ? pos_q + 6'd1 : pos_q;
    rem_d     = rem_q;
    kind_d    = kind_q;
    hdr_d     = hdr_q;
    stopped_d = stopped_q;
    seen_d    = seen_q;
    store_d   = store_q;
    name_d    = name_q;
    count_d   = count_q;
    name_hit  = 1'b0;
    if (active) begin
      case (hdr_q)
        adfp_pkg::HDR_LEN: begin
          // length byte counts itself in the bounds check
          if (item_i.ad_byte == 8'd0 || end_pos > 9'(item_i.report_length)) begin
            stopped_d = 1'b1;
            if (item_i.ad_byte != 8'd0 && name_q == adfp_pkg::NAME_NONE) begin
              name_d = adfp_pkg::NAME_UNKNOWN;
            end
          end else begin
            rem_d = item_i.ad_byte - 8'd1;
            hdr_d = adfp_pkg::HDR_TYPE;
          end
        end
        adfp_pkg::HDR_TYPE: begin
          kind_d = item_i.ad_byte;
          if (is_name(item_i.ad_byte) && name_q == adfp_pkg::NAME_NONE) begin
            if (rem_q > 8'(NAME_MAX)) begin
              name_d = adfp_pkg::NAME_UNKNOWN;
            end else if (rem_q == 8'd0) begin
              name_d = adfp_pkg::NAME_FOUND;
            end else begin
              name_d = adfp_pkg::NAME_STREAM;
            end
          end
          hdr_d = (rem_q == 8'd0) ? adfp_pkg::HDR_LEN : adfp_pkg::HDR_DATA;
        end
        adfp_pkg::HDR_DATA: begin
          if (kind_q == adfp_pkg::AD_FLAGS && !seen_q) begin
            seen_d  = 1'b1;
            store_d = item_i.ad_byte;
          end
          if (name_q == adfp_pkg::NAME_STREAM && is_name(kind_q)) begin
            name_hit = 1'b1;
            count_d  = count_q + 5'd1;
          end
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            hdr_d = adfp_pkg::HDR_LEN;
            if (name_q == adfp_pkg::NAME_STREAM) begin
              name_d = adfp_pkg::NAME_FOUND;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // filter decision and result words
  always_comb begin
    case (mode_i)
      adfp_pkg::DISC_ALL:     pass = 1'b1;
      adfp_pkg::DISC_LIMITED: pass = seen_d && ((store_d & adfp_pkg::FLAG_LIMITED) != 8'd0);
      adfp_pkg::DISC_GENERAL: pass = seen_d &&
          ((store_d & (adfp_pkg::FLAG_LIMITED | adfp_pkg::FLAG_GENERAL)) != 8'd0);
      default:                pass = 1'b0;
    endcase

    res_o                          = '0;
    res_o.name_vld                 = fire_i && name_hit;
    res_o.name_res.name_char       = item_i.ad_byte;
    res_o.name_res.name_char_valid = 1'b1;
    res_o.sum_vld                  = fire_i && item_i.last_byte;
    res_o.sum_res.report_done      = 1'b1;
    res_o.sum_res.accept           = pass;
    res_o.sum_res.flags_found      = seen_d;
    res_o.sum_res.flags_value      = seen_d ? store_d : 8'd0;
    res_o.sum_res.name_status      = !(name_d == adfp_pkg::NAME_STREAM ||
                                       name_d == adfp_pkg::NAME_FOUND);
    res_o.sum_res.name_length      = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      rem_q     <= '0;
      kind_q    <= '0;
      hdr_q     <= adfp_pkg::HDR_LEN;
      stopped_q <= 1'b0;
      seen_q    <= 1'b0;
      store_q   <= '0;
      name_q    <= adfp_pkg::NAME_NONE;
      count_q   <= '0;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        // summary given: start afresh for the next report
        pos_q     <= '0;
        rem_q     <= '0;
        kind_q    <= '0;
        hdr_q     <= adfp_pkg::HDR_LEN;
        stopped_q <= 1'b0;
        seen_q    <= 1'b0;
        store_q   <= '0;
        name_q    <= adfp_pkg::NAME_NONE;
        count_q   <= '0;
      end else begin
        pos_q     <= pos_d;
        rem_q     <= rem_d;
        kind_q    <= kind_d;
        hdr_q     <= hdr_d;
        stopped_q <= stopped_d;
        seen_q    <= seen_d;
        store_q   <= store_d;
        name_q    <= name_d;
        count_q   <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/advertising_data_filter_parser.sv */
// Top level: input register, LTV walker and a small result queue.
// Depends on adfp_pkg and adfp_walk.
`default_nettype none

// Advertising data parser. Bytes of one report enter on the in channel, one per
// transfer, with the report length and a last-byte mark; a new byte is taken every
// cycle unless in_stall_o is high. Each byte goes through an input register and one
// step of the LTV walker, then into a four-entry result queue. A byte gives no
// result, a name byte, a summary, or both (name byte first). The queue takes a
// byte only while two entries are free, so the rate is one byte per cycle while
// the queue has room; a byte with both a name byte and a summary fills two entries.
// The user must write discovery_mode through cfg_wr_en_i only between reports;
// the block itself does not enforce this.
module advertising_data_filter_parser #(
  parameter int NAME_MAX = 29
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_wr_en_i,
  input  wire  [1:0]         cfg_wr_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  adfp_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output adfp_pkg::out_t     out_data_o
);

  localparam int PtrW = adfp_pkg::FIFO_PTR_W;
  localparam int CntW = adfp_pkg::FIFO_CNT_W;

  adfp_pkg::disc_e     mode_q;
  logic                in_vld_q, in_vld_d;
  adfp_pkg::in_t       in_q;
  logic                room;
  logic                consume;
  adfp_pkg::walk_res_t res;

  adfp_pkg::out_t      mem_q [adfp_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, sum_addr;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [1:0]          push_n;
  logic                pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= adfp_pkg::DISC_ALL;
    end else if (cfg_wr_en_i) begin
      mode_q <= adfp_pkg::disc_e'(cfg_wr_data_i);
    end
  end

  // input register
  assign room       = cnt_q <= CntW'(adfp_pkg::FIFO_DEPTH - 2);
  assign consume    = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
    end else if (consume) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  adfp_walk #(
    .NAME_MAX (NAME_MAX)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (consume),
    .item_i (in_q),
    .mode_i (mode_q),
    .res_o  (res)
  );

  // result queue
  assign push_n   = {1'b0, res.name_vld} + {1'b0, res.sum_vld};
  assign pop      = out_valid_o && !out_stall_i;
  assign sum_addr = wr_ptr_q + PtrW'(res.name_vld);
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (res.name_vld) begin
      mem_q[wr_ptr_q] <= res.name_res;
    end
    if (res.sum_vld) begin
      mem_q[sum_addr] <= res.sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(adfp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_summary_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_q.last_byte) |=> out_valid_o)
    else $error("summary not queued after last byte");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("stall raised with empty input register");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.name_char_valid && out_data_o.report_done))
    else $error("result is both name byte and summary");
`endif

endmodule

`default_nettype wire
